/* src/smpd_pkg.sv */
// Types, codes and decode tables for the serial pointing-device packet decoder.
// No dependencies.
package smpd_pkg;

  typedef enum logic [1:0] {
    PROTO_7BIT3   = 2'd0,
    PROTO_8BIT3   = 2'd1,
    PROTO_8BIT5   = 2'd2,
    PROTO_SIGNMAG = 2'd3
  } proto_t;

  typedef enum logic [2:0] {
    CFG_PROTOCOL = 3'd0,
    CFG_X_MIN    = 3'd1,
    CFG_Y_MIN    = 3'd2,
    CFG_X_MAX    = 3'd3,
    CFG_Y_MAX    = 3'd4
  } cfg_reg_t;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 15;
  localparam int unsigned BOX_BITS       = 15;
  localparam int unsigned SUM_BITS       = 18;

  localparam logic [BOX_BITS-1:0] X_MAX_RESET = 15'd639;
  localparam logic [BOX_BITS-1:0] Y_MAX_RESET = 15'd399;

  typedef struct packed {
    logic [14:0] cursor_x;
    logic [14:0] cursor_y;
    logic [3:0]  button_bits;
    logic [7:0]  delta_x;
    logic [7:0]  delta_y;
  } result_t;

  function automatic logic [7:0] hdr_mask(input proto_t p);
    case (p)
      PROTO_7BIT3:   hdr_mask = 8'h40;
      PROTO_8BIT3:   hdr_mask = 8'hf8;
      PROTO_8BIT5:   hdr_mask = 8'hf8;
      PROTO_SIGNMAG: hdr_mask = 8'he0;
      default:       hdr_mask = 8'h40;
    endcase
  endfunction

  function automatic logic [7:0] hdr_id(input proto_t p);
    case (p)
      PROTO_7BIT3: hdr_id = 8'h40;
      default:     hdr_id = 8'h80;
    endcase
  endfunction

  function automatic logic [2:0] pkt_len(input proto_t p);
    case (p)
      PROTO_8BIT5: pkt_len = 3'd5;
      default:     pkt_len = 3'd3;
    endcase
  endfunction

  // lower bound first, then upper; min > max yields max
  function automatic logic [BOX_BITS-1:0] clamp_axis(input logic signed [SUM_BITS-1:0] s,
                                                     input logic [BOX_BITS-1:0] lo,
                                                     input logic [BOX_BITS-1:0] hi);
    logic signed [SUM_BITS-1:0] lo_s;
    logic signed [SUM_BITS-1:0] hi_s;
    logic signed [SUM_BITS-1:0] v;
    lo_s = $signed({3'b000, lo});
    hi_s = $signed({3'b000, hi});
    v = s;
    if (v < lo_s) v = lo_s;
    if (v > hi_s) v = hi_s;
    clamp_axis = v[BOX_BITS-1:0];
  endfunction

  function automatic logic [3:0] map_buttons(input logic [2:0] raw);
    if (raw == 3'd3) begin
      map_buttons = 4'b0100;
    end else begin
      map_buttons = {raw[0], 1'b0, raw[1], 1'b0};
    end
  endfunction

endpackage

/* src/serial_mouse_packet_decoder_core.sv */
// A result beat is registered from the last byte of its packet: into the output register, or into the skid if stalled.
// Throughput: one input beat per cycle while in_stall is low; the cursor and byte phase update at acceptance.
// An output register plus one skid register; in_stall rises only when both are full.
// Reset (rst, synchronous): hunting for a header, cursor at 320/320, protocol 0,
// box 0..639 by 0..399, no result pending. Collected bytes are not cleared.
module serial_mouse_packet_decoder_core
  import smpd_pkg::*;
#(
  parameter int unsigned COORD_BITS = 15
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [7:0]                rx_byte,
  input  logic [14:0]               load_x,
  input  logic [14:0]               load_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [14:0]               cursor_x,
  output logic [14:0]               cursor_y,
  output logic [3:0]                button_bits,
  output logic signed [7:0]         delta_x,
  output logic signed [7:0]         delta_y
);

  localparam logic [COORD_BITS-1:0] POS_RESET = COORD_BITS'(320);

  proto_t               protocol;
  logic [BOX_BITS-1:0]  x_min, y_min, x_max, y_max;
  logic [2:0]           byte_phase, byte_phase_next;
  logic [7:0]           packet_bytes [4];
  logic                 pb_we;
  logic [COORD_BITS-1:0] pos_x, pos_y, pos_x_next, pos_y_next;

  logic                 in_acc;
  logic                 res_valid;
  result_t              res;
  result_t              out_reg;
  result_t              skid;
  logic                 skid_valid;
  logic                 out_free;

  logic [2:0] len;
  logic [7:0] b0, b1, b2, b3, b4;
  logic [2:0] raw;
  logic [7:0] dx, dy;
  logic signed [SUM_BITS-1:0] sum_x, sum_y;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  // packet bytes as seen at the closing beat
  always_comb begin
    len = pkt_len(protocol);
    b0  = packet_bytes[0];
    b1  = packet_bytes[1];
    b3  = packet_bytes[3];
    if (len == 3'd5) begin
      b2 = packet_bytes[2];
      b4 = rx_byte;
    end else begin
      b2 = rx_byte;
      b4 = 8'h00;
    end
  end

  always_comb begin
    case (protocol)
      PROTO_7BIT3: begin
        raw = {1'b0, b0[5], b0[4]};
        dx  = {b0[1:0], b1[5:0]};
        dy  = {b0[3:2], b2[5:0]};
      end
      PROTO_8BIT3: begin
        raw = ~b0[2:0];
        dx  = b1;
        dy  = 8'h00 - b2;
      end
      PROTO_8BIT5: begin
        raw = ~b0[2:0];
        dx  = b1 + b3;
        dy  = 8'h00 - (b2 + b4);
      end
      default: begin
        raw = b0[2:0];
        dx  = b0[4] ? b1 : 8'h00 - b1;
        dy  = b0[3] ? 8'h00 - b2 : b2;
      end
    endcase
  end

  assign sum_x = $signed({2'b00, 16'(pos_x)}) + $signed({{(SUM_BITS-8){dx[7]}}, dx});
  assign sum_y = $signed({2'b00, 16'(pos_y)}) + $signed({{(SUM_BITS-8){dy[7]}}, dy});

  always_comb begin
    byte_phase_next = byte_phase;
    pb_we           = 1'b0;
    pos_x_next      = pos_x;
    pos_y_next      = pos_y;
    res_valid       = 1'b0;
    if (in_acc) begin
      if (action == ACT_LOAD) begin
        pos_x_next = COORD_BITS'(load_x);
        pos_y_next = COORD_BITS'(load_y);
      end else if (byte_phase == 3'd0) begin
        if ((rx_byte & hdr_mask(protocol)) == hdr_id(protocol)) begin
          pb_we           = 1'b1;
          byte_phase_next = 3'd1;
        end
      end else if ((byte_phase + 3'd1) < len) begin
        pb_we           = 1'b1;
        byte_phase_next = byte_phase + 3'd1;
      end else begin
        byte_phase_next = 3'd0;
        res_valid       = 1'b1;
        if (dx != 8'h00 || dy != 8'h00) begin
          pos_x_next = COORD_BITS'(clamp_axis(sum_x, x_min, x_max));
          pos_y_next = COORD_BITS'(clamp_axis(sum_y, y_min, y_max));
        end
      end
    end
  end

  always_comb begin
    res.cursor_x    = 15'(pos_x_next);
    res.cursor_y    = 15'(pos_y_next);
    res.button_bits = map_buttons(raw);
    res.delta_x     = dx;
    res.delta_y     = dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol   <= PROTO_7BIT3;
      x_min      <= '0;
      y_min      <= '0;
      x_max      <= X_MAX_RESET;
      y_max      <= Y_MAX_RESET;
      byte_phase <= 3'd0;
      pos_x      <= POS_RESET;
      pos_y      <= POS_RESET;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PROTOCOL: protocol <= proto_t'(cfg_data[1:0]);
          CFG_X_MIN:    x_min    <= cfg_data;
          CFG_Y_MIN:    y_min    <= cfg_data;
          CFG_X_MAX:    x_max    <= cfg_data;
          CFG_Y_MAX:    y_max    <= cfg_data;
          default: ;
        endcase
      end
      byte_phase <= byte_phase_next;
      pos_x      <= pos_x_next;
      pos_y      <= pos_y_next;
      if (out_free) begin
        out_valid <= skid_valid || res_valid;
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end
      end else if (res_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // payload: skid only fills while out is stalled; skid being full blocks input
  always_ff @(posedge clk) begin
    if (pb_we) begin
      packet_bytes[byte_phase[1:0]] <= rx_byte;
    end
    if (out_free) begin
      if (skid_valid) begin
        out_reg <= skid;
      end else if (res_valid) begin
        out_reg <= res;
      end
    end else if (res_valid) begin
      skid <= res;
    end
  end

  assign cursor_x    = out_reg.cursor_x;
  assign cursor_y    = out_reg.cursor_y;
  assign button_bits = out_reg.button_bits;
  assign delta_x     = $signed(out_reg.delta_x);
  assign delta_y     = $signed(out_reg.delta_y);

endmodule
